>>> hw/rtl/kmh_pkg.sv
// ----------------------------------------------------------------------------
// kmh_pkg
// Types and constants shared by the k-nearest max-heap block.
// ----------------------------------------------------------------------------
package kmh_pkg;

  localparam int KEY_W = 32;
  localparam int TAG_W = 16;
  localparam int CNT_W = 7;
  localparam int CAP_W = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } kmh_cmd_t;

  typedef struct packed {
    kmh_cmd_t           cmd;
    logic [KEY_W-1:0]   distance_key;
    logic [TAG_W-1:0]   item_tag;
  } kmh_in_t;

  typedef struct packed {
    logic [KEY_W-1:0]   top_distance;
    logic [TAG_W-1:0]   top_tag;
    logic [CNT_W-1:0]   entry_count;
    logic               is_full;
    logic               stored;
    logic               empty_error;
  } kmh_out_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [TAG_W-1:0]   tag;
  } kmh_entry_t;

endpackage

>>> hw/rtl/kmh_ram.sv
// ----------------------------------------------------------------------------
// kmh_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module kmh_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> hw/rtl/kmh_ctrl.sv
// ----------------------------------------------------------------------------
// kmh_ctrl
// Heap sequencer: sift-up and sift-down over the entry RAM, one level a cycle.
// ----------------------------------------------------------------------------
module kmh_ctrl #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  kmh_pkg::kmh_in_t     item,
  input  logic [((($clog2(MAX_ENTRIES+1)) > kmh_pkg::CAP_W) ?
                 $clog2(MAX_ENTRIES+1) : kmh_pkg::CAP_W)-1:0] cap_eff,
  input  logic                 res_free,
  output logic                 ready,
  output logic                 done,
  output kmh_pkg::kmh_out_t    res
);
  import kmh_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;
  localparam int DW = $bits(kmh_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CMP,
    ST_DEL_RD,
    ST_DN_CMP,
    ST_PLACE,
    ST_DONE
  } state_t;

  state_t          state, state_next;
  logic [CW-1:0]   fill_count, fill_count_next;
  logic [CW-1:0]   hole, hole_next;
  logic [CW-1:0]   limit, limit_next;
  kmh_entry_t      pend, pend_next;
  kmh_entry_t      root, root_next;
  logic            stored, stored_next;
  logic            err, err_next;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr_a, ram_raddr_b;
  kmh_entry_t      ram_wdata;
  logic [DW-1:0]   ram_rdata_a, ram_rdata_b;

  logic            kids_req;
  logic [CW-1:0]   kids_parent;
  logic [CW:0]     kl, kr;
  kmh_entry_t      dl, dr, big_e;
  logic [CW:0]     cl, cr, big_i;
  logic            has_r, go, big_r;
  logic [CW-1:0]   par;

  function automatic logic [AW-1:0] idx_addr(input logic [CW:0] idx);
    logic [CW:0] a;
    a = idx - 1'b1;
    return a[AW-1:0];
  endfunction

  function automatic logic has_kid(input logic [CW-1:0] h, input logic [CW-1:0] lim);
    return {h, 1'b0} <= {1'b0, lim};
  endfunction

  kmh_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    hole_next       = hole;
    limit_next      = limit;
    pend_next       = pend;
    root_next       = root;
    stored_next     = stored;
    err_next        = err;
    ram_we          = 1'b0;
    ram_waddr       = idx_addr({1'b0, hole});
    ram_wdata       = pend;
    ram_re          = 1'b0;
    ram_raddr_a     = '0;
    ram_raddr_b     = '0;
    kids_req        = 1'b0;
    kids_parent     = CW'(1);
    done            = 1'b0;

    dl    = kmh_entry_t'(ram_rdata_a);
    dr    = kmh_entry_t'(ram_rdata_b);
    cl    = {hole, 1'b0};
    cr    = cl + 1'b1;
    has_r = cr <= {1'b0, limit};
    go    = (dl.key > pend.key) || (has_r && (dr.key > pend.key));
    big_r = has_r && (dr.key > dl.key);
    big_e = big_r ? dr : dl;
    big_i = big_r ? cr : cl;
    par   = hole >> 1;

    case (state)
      ST_IDLE: begin
        if (start) begin
          pend_next   = '{key: item.distance_key, tag: item.item_tag};
          stored_next = 1'b0;
          err_next    = 1'b0;
          case (item.cmd)
            CMD_INSERT: begin
              if (EW'(fill_count) < cap_eff) begin
                fill_count_next = fill_count + 1'b1;
                hole_next       = fill_count_next;
                stored_next     = 1'b1;
                if (fill_count == '0) begin
                  state_next = ST_PLACE;
                end else begin
                  ram_re      = 1'b1;
                  ram_raddr_a = idx_addr({1'b0, fill_count_next >> 1});
                  state_next  = ST_UP_CMP;
                end
              end else if (root.key > item.distance_key) begin
                stored_next = 1'b1;
                hole_next   = CW'(1);
                limit_next  = fill_count;
                if (has_kid(CW'(1), fill_count)) begin
                  kids_req   = 1'b1;
                  state_next = ST_DN_CMP;
                end else begin
                  state_next = ST_PLACE;
                end
              end else begin
                state_next = ST_DONE;
              end
            end
            CMD_DELETE: begin
              if (fill_count == '0) begin
                err_next   = 1'b1;
                state_next = ST_DONE;
              end else begin
                ram_re          = 1'b1;
                ram_raddr_a     = idx_addr({1'b0, fill_count});
                fill_count_next = fill_count - 1'b1;
                limit_next      = fill_count - 1'b1;
                state_next      = ST_DEL_RD;
              end
            end
            CMD_CLEAR: begin
              fill_count_next = '0;
              state_next      = ST_DONE;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_UP_CMP: begin
        ram_we = 1'b1;
        if (dl.key < pend.key) begin
          ram_wdata = dl;
          hole_next = par;
          if (par > CW'(1)) begin
            ram_re      = 1'b1;
            ram_raddr_a = idx_addr({1'b0, par >> 1});
          end else begin
            state_next = ST_PLACE;
          end
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DEL_RD: begin
        pend_next = dl;
        hole_next = CW'(1);
        if (limit == '0) begin
          state_next = ST_DONE;
        end else if (has_kid(CW'(1), limit)) begin
          kids_req   = 1'b1;
          state_next = ST_DN_CMP;
        end else begin
          state_next = ST_PLACE;
        end
      end
      ST_DN_CMP: begin
        ram_we = 1'b1;
        if (!go) begin
          if (hole == CW'(1)) begin
            root_next = pend;
          end
          state_next = ST_DONE;
        end else begin
          ram_wdata = big_e;
          if (hole == CW'(1)) begin
            root_next = big_e;
          end
          hole_next = big_i[CW-1:0];
          if (has_kid(big_i[CW-1:0], limit)) begin
            kids_req    = 1'b1;
            kids_parent = big_i[CW-1:0];
          end else begin
            state_next = ST_PLACE;
          end
        end
      end
      ST_PLACE: begin
        ram_we = 1'b1;
        if (hole == CW'(1)) begin
          root_next = pend;
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_free) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // children of kids_parent, second port falls back to the left child
    kl = {kids_parent, 1'b0};
    kr = kl + 1'b1;
    if (kids_req) begin
      ram_re      = 1'b1;
      ram_raddr_a = idx_addr(kl);
      ram_raddr_b = (kr <= {1'b0, limit_next}) ? idx_addr(kr) : idx_addr(kl);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
    end
    hole   <= hole_next;
    limit  <= limit_next;
    pend   <= pend_next;
    root   <= root_next;
    stored <= stored_next;
    err    <= err_next;
  end

  assign ready = (state == ST_IDLE);

  always_comb begin
    res.top_distance = (fill_count != '0) ? root.key : '0;
    res.top_tag      = (fill_count != '0) ? root.tag : '0;
    res.entry_count  = CNT_W'(fill_count);
    res.is_full      = (EW'(fill_count) >= cap_eff);
    res.stored       = stored;
    res.empty_error  = err;
  end

`ifndef SYNTHESIS
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr_a && ram_waddr != ram_raddr_b))
    else $error("heap ram read and write hit the same entry");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(MAX_ENTRIES))
    else $error("fill count beyond heap depth");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == ST_IDLE))
    else $error("operation started while busy");

  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    (done && err) |-> (fill_count == '0 && !stored))
    else $error("empty error on a non-empty heap");

  a_hole_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UP_CMP || state == ST_DN_CMP || state == ST_PLACE) |-> (hole != '0))
    else $error("heap hole at index zero");
`endif

endmodule

>>> hw/rtl/k_nearest_max_heap.sv
// ----------------------------------------------------------------------------
// k_nearest_max_heap
// Bounded max-heap keeping the k nearest (key, tag) candidates.
// ----------------------------------------------------------------------------
// item channel: one command per transfer (insert, delete max, clear, no-op)
// with a distance key and tag. result channel: one transfer per command with
// the root entry, count, full flag, stored flag and empty error.
// cfg channel: writes the capacity; write only while no command is in flight.
// Entries live in one RAM with registered reads, and a command walks the
// heap one level per cycle. Clear, no-op, a dropped insert and a failed
// delete go straight to the result state; an insert or delete that walks
// the heap first passes through it level by level, so the heap depth sets
// how long it takes. The next item is taken once the sequencer is back in
// idle after the result is registered. One command is processed at a
// time; a new item is taken as soon as the sequencer is idle, even while
// the last result still waits in the output register. If that register is
// still full when the next result is ready, the sequencer holds until the
// receiver takes the old one.
// Reset empties the heap and sets capacity to 64; no clearing pass is needed.
// ----------------------------------------------------------------------------
module k_nearest_max_heap #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  kmh_pkg::kmh_in_t             item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output kmh_pkg::kmh_out_t            result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [kmh_pkg::CAP_W-1:0]    cfg_data
);
  import kmh_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0] capacity;
  logic [EW-1:0]    cap_eff;
  logic             ctrl_ready, ctrl_done, res_free, start;
  kmh_out_t         ctrl_res;

  assign cfg_ready  = 1'b1;
  assign item_ready = ctrl_ready;
  assign start      = item_valid && item_ready;
  assign res_free   = !result_valid || result_ready;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = EW'(1);
    end else if (EW'(capacity) > EW'(MAX_ENTRIES)) begin
      cap_eff = EW'(MAX_ENTRIES);
    end else begin
      cap_eff = EW'(capacity);
    end
  end

  kmh_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .cap_eff  (cap_eff),
    .res_free (res_free),
    .ready    (ctrl_ready),
    .done     (ctrl_done),
    .res      (ctrl_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= CAP_RESET;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (ctrl_done) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (ctrl_done) begin
      result <= ctrl_res;
    end
  end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded k-nearest max-heap. Commands are queued
// by a stimulus process and sent in random bursts. Each accepted command is
// run through a local copy of the heap and its capacity register, and the
// resulting report is compared field by field with the block's output. The
// capacity is changed only between phases, after the block has drained.
// ----------------------------------------------------------------------------
module tb_top;
  import kmh_pkg::*;

  localparam int          HEAP_DEPTH = 64;
  localparam int unsigned LONG_HOLD  = 300;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             item_valid   = 1'b0;
  logic             item_ready;
  kmh_in_t          item         = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  kmh_out_t         result;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data     = '0;

  // local heap copy
  logic [KEY_W-1:0] heap_key [1:HEAP_DEPTH];
  logic [TAG_W-1:0] heap_tag [1:HEAP_DEPTH];
  int unsigned      heap_fill = 0;
  logic [CAP_W-1:0] cap_reg   = CAP_RESET;

  kmh_in_t     pending_cmds [$];
  kmh_out_t    owed_reports [$];
  int unsigned mismatch_count = 0;

  int unsigned burst_left    = 1;
  int unsigned gap_left      = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned mode_left     = 0;
  int unsigned stall_mode    = 0;

  k_nearest_max_heap #(
    .MAX_ENTRIES(HEAP_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned cap_limit();
    if (cap_reg == 0) return 1;
    if (cap_reg > HEAP_DEPTH) return HEAP_DEPTH;
    return cap_reg;
  endfunction

  function automatic void heap_sink(logic [KEY_W-1:0] k, logic [TAG_W-1:0] t,
                                    int unsigned n);
    int unsigned hole, lc, rc, big;
    hole = 1;
    while (2 * hole <= n) begin
      lc = 2 * hole;
      rc = lc + 1;
      if (!(heap_key[lc] > k || (rc <= n && heap_key[rc] > k))) break;
      big = (rc <= n && heap_key[rc] > heap_key[lc]) ? rc : lc;
      heap_key[hole] = heap_key[big];
      heap_tag[hole] = heap_tag[big];
      hole = big;
    end
    heap_key[hole] = k;
    heap_tag[hole] = t;
  endfunction

  function automatic void heap_rise(logic [KEY_W-1:0] k, logic [TAG_W-1:0] t,
                                    int unsigned start);
    int unsigned hole;
    hole = start;
    while (hole > 1 && heap_key[hole / 2] < k) begin
      heap_key[hole] = heap_key[hole / 2];
      heap_tag[hole] = heap_tag[hole / 2];
      hole = hole / 2;
    end
    heap_key[hole] = k;
    heap_tag[hole] = t;
  endfunction

  function automatic kmh_out_t heap_apply(kmh_in_t it);
    kmh_out_t         r;
    int unsigned      lim;
    logic [KEY_W-1:0] last_key;
    logic [TAG_W-1:0] last_tag;
    r = '0;
    lim = cap_limit();
    case (it.cmd)
      CMD_INSERT: begin
        if (heap_fill < lim) begin
          heap_fill++;
          heap_rise(it.distance_key, it.item_tag, heap_fill);
          r.stored = 1'b1;
        end else if (heap_key[1] > it.distance_key) begin
          heap_sink(it.distance_key, it.item_tag, heap_fill);
          r.stored = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (heap_fill == 0) begin
          r.empty_error = 1'b1;
        end else begin
          last_key = heap_key[heap_fill];
          last_tag = heap_tag[heap_fill];
          heap_fill--;
          if (heap_fill > 0) heap_sink(last_key, last_tag, heap_fill);
        end
      end
      CMD_CLEAR: heap_fill = 0;
      default: ;
    endcase
    if (heap_fill != 0) begin
      r.top_distance = heap_key[1];
      r.top_tag      = heap_tag[1];
    end
    r.entry_count = heap_fill[CNT_W-1:0];
    r.is_full     = (heap_fill >= lim);
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 15);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 7);
      default: return $urandom >> $urandom_range(1, 28);
    endcase
  endfunction

  // driver: bursts of transfers with random gaps
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        owed_reports.push_back(heap_apply(item));
      end
      if (!item_valid || item_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          item <= pending_cmds.pop_front();
          item_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
              0, 1: gap_left = 0;
              2: gap_left = $urandom_range(1, 3);
              default: gap_left = $urandom_range(4, 20);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD;
      result_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 60);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: result_ready <= 1'b1;
        1: result_ready <= 1'($urandom_range(0, 1));
        default: result_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    kmh_out_t want;
    if (!rst && result_valid && result_ready) begin
      if (owed_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transfer: dist=%h tag=%h cnt=%0d full=%b st=%b err=%b",
                   result.top_distance, result.top_tag, result.entry_count,
                   result.is_full, result.stored, result.empty_error);
      end else begin
        want = owed_reports.pop_front();
        if (result.top_distance !== want.top_distance || result.top_tag !== want.top_tag ||
            result.entry_count !== want.entry_count || result.is_full !== want.is_full ||
            result.stored !== want.stored || result.empty_error !== want.empty_error) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("want: dist=%h tag=%h cnt=%0d full=%b st=%b err=%b",
                     want.top_distance, want.top_tag, want.entry_count,
                     want.is_full, want.stored, want.empty_error);
            $display("got:  dist=%h tag=%h cnt=%0d full=%b st=%b err=%b",
                     result.top_distance, result.top_tag, result.entry_count,
                     result.is_full, result.stored, result.empty_error);
          end
        end
      end
    end
  end

  task automatic queue_item(input kmh_cmd_t c, input logic [KEY_W-1:0] k,
                            input logic [TAG_W-1:0] t);
    kmh_in_t it;
    it.cmd = c;
    it.distance_key = k;
    it.item_tag = t;
    pending_cmds.push_back(it);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || item_valid || owed_reports.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cap_reg = v;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int unsigned n,
                           input int unsigned ins_w, input int unsigned del_w,
                           input int unsigned clr_w, input bit hold);
    kmh_cmd_t    c;
    int unsigned r;
    wait_drained();
    write_capacity(cap);
    if (hold) hold_requests++;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < ins_w) c = CMD_INSERT;
      else if (r < ins_w + del_w) c = CMD_DELETE;
      else if (r < ins_w + del_w + clr_w) c = CMD_CLEAR;
      else c = CMD_NOP;
      queue_item(c, rand_key(), TAG_W'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty heap, extremes, equal keys, no-op
    queue_item(CMD_DELETE, 32'h0, 16'h0);
    queue_item(CMD_NOP, 32'hFFFF_FFFF, 16'hFFFF);
    queue_item(CMD_INSERT, 32'h0, 16'h0);
    queue_item(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
    queue_item(CMD_INSERT, 32'd5, 16'h1234);
    queue_item(CMD_INSERT, 32'd5, 16'hABCD);
    queue_item(CMD_DELETE, 32'h0, 16'h0);
    queue_item(CMD_NOP, 32'h0, 16'h0);
    queue_item(CMD_CLEAR, 32'h0, 16'h0);
    queue_item(CMD_DELETE, 32'h0, 16'h0);
    wait_drained();

    // full heap: replace, drop larger, drop equal
    write_capacity(7'd2);
    queue_item(CMD_INSERT, 32'd10, 16'h0010);
    queue_item(CMD_INSERT, 32'd20, 16'h0020);
    queue_item(CMD_INSERT, 32'd30, 16'h0030);
    queue_item(CMD_INSERT, 32'd20, 16'h0021);
    queue_item(CMD_INSERT, 32'd15, 16'h0015);
    queue_item(CMD_INSERT, 32'd0, 16'h5555);
    queue_item(CMD_DELETE, 32'h0, 16'h0);
    queue_item(CMD_DELETE, 32'h0, 16'h0);
    queue_item(CMD_DELETE, 32'h0, 16'h0);
    wait_drained();

    // zero capacity acts as one
    write_capacity(7'd0);
    queue_item(CMD_INSERT, 32'd7, 16'hAAAA);
    queue_item(CMD_INSERT, 32'd3, 16'h8001);
    queue_item(CMD_INSERT, 32'd3, 16'h7FFE);
    queue_item(CMD_DELETE, 32'h0, 16'h0);

    run_phase(7'd64, 150, 85, 12, 1, 1'b0);
    run_phase(7'd4, 100, 70, 25, 0, 1'b0);    // capacity below count
    run_phase(7'd127, 200, 80, 15, 2, 1'b0);
    run_phase(7'd1, 80, 60, 30, 5, 1'b0);
    run_phase(7'd0, 60, 60, 30, 5, 1'b0);
    run_phase(7'd2, 80, 60, 30, 5, 1'b0);
    run_phase(CAP_W'($urandom_range(1, 64)), 150, 55, 40, 3, 1'b0);
    run_phase(7'd8, 120, 65, 30, 3, 1'b0);
    run_phase(7'd16, 60, 70, 25, 3, 1'b1);
    run_phase(7'd64, 200, 55, 42, 1, 1'b0);
    run_phase(CAP_W'($urandom_range(3, 12)), 120, 60, 35, 3, 1'b0);
    run_phase(7'd32, 150, 75, 20, 3, 1'b0);
    run_phase(7'd100, 150, 85, 13, 0, 1'b0);
    run_phase(7'd64, 80, 20, 78, 0, 1'b0);
    wait_drained();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/kmh_pkg.sv
hw/rtl/kmh_ram.sv
hw/rtl/kmh_ctrl.sv
hw/rtl/k_nearest_max_heap.sv
test/tb_top.sv
